@@ hw/rtl/modular_arithmetic_unit_macros.svh @@
// Assertion macros for the modular arithmetic unit
`ifndef MODULAR_ARITHMETIC_UNIT_MACROS_SVH
`define MODULAR_ARITHMETIC_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MAU_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define MAU_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define MAU_ASSERT_NOW(lbl, pre, post)
`define MAU_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ hw/rtl/mau_pkg.sv @@
// Shared types and constants for the modular arithmetic unit
`timescale 1ns / 1ps
package mau_pkg;
    localparam int RES_W = 31;
    localparam int OPERAND_BITS_DEF = 63;
    localparam logic [RES_W-1:0] MODULUS_RESET = 31'd1000000007;

    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_DIV = 3'd3;
    localparam logic [2:0] ACT_INV = 3'd4;
    localparam logic [2:0] ACT_POW = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_A,
        ST_RED_B,
        ST_DISPATCH,
        ST_EUC_CHECK,
        ST_EUC_DIV,
        ST_EUC_UPD,
        ST_POW_CHECK,
        ST_POW_ACC,
        ST_POW_SQ,
        ST_MUL_DBL,
        ST_MUL_ADD,
        ST_MUL_RES,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [RES_W-1:0] x;
        logic [RES_W-1:0] y;
        logic             cin;
        logic [RES_W-1:0] d;
        logic             sub;
    } alu_ctl_t;
endpackage

@@ hw/rtl/mau_alu.sv @@
// Shared add/subtract unit with conditional correction by the divisor
`timescale 1ns / 1ps
module mau_alu (
    input  mau_pkg::alu_ctl_t           ctl,
    output logic [mau_pkg::RES_W-1:0]   res,
    output logic                        ge
);
    import mau_pkg::*;

    logic [RES_W:0] sum;
    logic [RES_W:0] diff;
    logic [RES_W:0] sum_red;
    logic [RES_W:0] diff_fix;

    assign sum      = {1'b0, ctl.x} + {1'b0, ctl.y} + {{RES_W{1'b0}}, ctl.cin};
    assign diff     = {1'b0, ctl.x} - {1'b0, ctl.y};
    assign sum_red  = sum - {1'b0, ctl.d};
    assign diff_fix = diff + {1'b0, ctl.d};

    always_comb
    begin
        if (ctl.sub)
        begin
            // borrow: wrap back into range
            ge  = diff[RES_W];
            res = ge ? diff_fix[RES_W-1:0] : diff[RES_W-1:0];
        end
        else
        begin
            ge  = (sum >= {1'b0, ctl.d});
            res = ge ? sum_red[RES_W-1:0] : sum[RES_W-1:0];
        end
    end
endmodule

@@ hw/rtl/mau_seq.sv @@
// Sequencer: reductions, Euclid, square-and-multiply over the shared unit
`timescale 1ns / 1ps
module mau_seq #(
    parameter int OPERAND_BITS = mau_pkg::OPERAND_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [2:0]                  action,
    input  logic [OPERAND_BITS-1:0]     operand_a,
    input  logic [OPERAND_BITS-1:0]     operand_b,
    input  logic [mau_pkg::RES_W-1:0]   modulus,
    input  logic                        out_free,
    output logic                        busy,
    output logic                        push,
    output logic [mau_pkg::RES_W-1:0]   res
);
    import mau_pkg::*;

    localparam int CW  = $clog2(OPERAND_BITS);
    localparam int MCW = $clog2(RES_W);
    localparam logic [CW-1:0]  CNT_TOP = CW'(OPERAND_BITS - 1);
    localparam logic [CW-1:0]  DIV_TOP = CW'(RES_W - 1);
    localparam logic [MCW-1:0] MUL_TOP = MCW'(RES_W - 1);
    localparam logic [RES_W-1:0] ONE   = RES_W'(1);

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    logic [2:0]              act_reg, act_next;
    logic [OPERAND_BITS-1:0] a_reg, a_next;
    logic [OPERAND_BITS-1:0] b_reg, b_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [RES_W-1:0]        rem_reg, rem_next;
    logic [RES_W-1:0]        ar_reg, ar_next;
    logic [RES_W-1:0]        br_reg, br_next;
    logic [RES_W-1:0]        r0_reg, r0_next;
    logic [RES_W-1:0]        r1_reg, r1_next;
    logic [RES_W-1:0]        s0_reg, s0_next;
    logic [RES_W-1:0]        s1_reg, s1_next;
    logic [RES_W-1:0]        q_reg, q_next;
    logic [RES_W-1:0]        mx_reg, mx_next;
    logic [RES_W-1:0]        my_reg, my_next;
    logic [RES_W-1:0]        macc_reg, macc_next;
    logic [MCW-1:0]          mcnt_reg, mcnt_next;
    logic [RES_W-1:0]        acc_reg, acc_next;
    logic [RES_W-1:0]        base_reg, base_next;
    logic [RES_W-1:0]        res_reg, res_next;

    alu_ctl_t         ctl;
    logic [RES_W-1:0] alu_res;
    logic             alu_ge;
    logic [RES_W-1:0] q_shift;

    mau_alu u_alu (
        .ctl (ctl),
        .res (alu_res),
        .ge  (alu_ge)
    );

    assign q_shift = {q_reg[RES_W-2:0], alu_ge};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (modulus < RES_W'(2) || action > ACT_POW)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_RED_A;
                end
            end
            ST_RED_A:     if (cnt_reg == '0) state_next = ST_RED_B;
            ST_RED_B:     if (cnt_reg == '0) state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                case (act_reg) inside
                    ACT_MUL:          state_next = ST_MUL_DBL;
                    ACT_DIV, ACT_INV: state_next = ST_EUC_CHECK;
                    ACT_POW:          state_next = ST_POW_CHECK;
                    default:          state_next = ST_FINISH;
                endcase
            end
            ST_EUC_CHECK:
            begin
                if (r1_reg != '0)
                    state_next = ST_EUC_DIV;
                else if (act_reg == ACT_INV)
                    state_next = ST_FINISH;
                else
                    state_next = ST_MUL_DBL;
            end
            ST_EUC_DIV:   if (cnt_reg == '0) state_next = ST_MUL_DBL;
            ST_EUC_UPD:   state_next = ST_EUC_CHECK;
            ST_POW_CHECK: state_next = (b_reg == '0) ? ST_FINISH : ST_MUL_DBL;
            ST_POW_ACC:   state_next = ST_MUL_DBL;
            ST_POW_SQ:    state_next = ST_POW_CHECK;
            ST_MUL_DBL:   state_next = ST_MUL_ADD;
            ST_MUL_ADD:   state_next = (mcnt_reg == '0) ? ret_reg : ST_MUL_DBL;
            ST_MUL_RES:   state_next = ST_FINISH;
            ST_FINISH:    if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy = (state_reg != ST_IDLE);
        push = (state_reg == ST_FINISH) && out_free;
        res  = res_reg;
    end

    // datapath
    always_comb
    begin
        ret_next  = ret_reg;
        act_next  = act_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        ar_next   = ar_reg;
        br_next   = br_reg;
        r0_next   = r0_reg;
        r1_next   = r1_reg;
        s0_next   = s0_reg;
        s1_next   = s1_reg;
        q_next    = q_reg;
        mx_next   = mx_reg;
        my_next   = my_reg;
        macc_next = macc_reg;
        mcnt_next = mcnt_reg;
        acc_next  = acc_reg;
        base_next = base_reg;
        res_next  = res_reg;
        ctl.x     = '0;
        ctl.y     = '0;
        ctl.cin   = 1'b0;
        ctl.d     = modulus;
        ctl.sub   = 1'b0;

        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (start)
                begin
                    act_next = action;
                    a_next   = operand_a;
                    b_next   = operand_b;
                    cnt_next = CNT_TOP;
                    rem_next = '0;
                    res_next = '0;
                end
            end
            ST_RED_A, ST_RED_B:
            begin
                // shift in one operand bit, subtract modulus when it fits
                ctl.x    = rem_reg;
                ctl.y    = rem_reg;
                ctl.cin  = (state_reg == ST_RED_A) ? a_reg[cnt_reg] : b_reg[cnt_reg];
                rem_next = alu_res;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    if (state_reg == ST_RED_A)
                        ar_next = alu_res;
                    else
                        br_next = alu_res;
                    rem_next = '0;
                    cnt_next = CNT_TOP;
                end
            end
            ST_DISPATCH:
            begin
                case (act_reg) inside
                    ACT_ADD, ACT_SUB:
                    begin
                        ctl.x    = ar_reg;
                        ctl.y    = br_reg;
                        ctl.sub  = (act_reg == ACT_SUB);
                        res_next = alu_res;
                    end
                    ACT_MUL:
                    begin
                        mx_next   = ar_reg;
                        my_next   = br_reg;
                        macc_next = '0;
                        mcnt_next = MUL_TOP;
                        ret_next  = ST_MUL_RES;
                    end
                    ACT_DIV, ACT_INV:
                    begin
                        r0_next = (act_reg == ACT_INV) ? ar_reg : br_reg;
                        r1_next = modulus;
                        s0_next = ONE;
                        s1_next = '0;
                    end
                    ACT_POW:
                    begin
                        acc_next  = ONE;
                        base_next = ar_reg;
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end
            ST_EUC_CHECK:
            begin
                if (r1_reg != '0)
                begin
                    rem_next = '0;
                    q_next   = '0;
                    cnt_next = DIV_TOP;
                end
                else if (act_reg == ACT_INV)
                begin
                    res_next = s0_reg;
                end
                else
                begin
                    mx_next   = ar_reg;
                    my_next   = s0_reg;
                    macc_next = '0;
                    mcnt_next = MUL_TOP;
                    ret_next  = ST_MUL_RES;
                end
            end
            ST_EUC_DIV:
            begin
                // restoring division r0 / r1, one quotient bit a cycle
                ctl.x    = rem_reg;
                ctl.y    = rem_reg;
                ctl.cin  = r0_reg[cnt_reg[MCW-1:0]];
                ctl.d    = r1_reg;
                rem_next = alu_res;
                q_next   = q_shift;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    mx_next   = s1_reg;
                    my_next   = q_shift;
                    macc_next = '0;
                    mcnt_next = MUL_TOP;
                    ret_next  = ST_EUC_UPD;
                end
            end
            ST_EUC_UPD:
            begin
                // coefficients kept as residues: s1 <- s0 - q*s1 mod m
                ctl.x   = s0_reg;
                ctl.y   = macc_reg;
                ctl.sub = 1'b1;
                r0_next = r1_reg;
                r1_next = rem_reg;
                s0_next = s1_reg;
                s1_next = alu_res;
            end
            ST_POW_CHECK:
            begin
                if (b_reg == '0)
                begin
                    res_next = acc_reg;
                end
                else
                begin
                    mx_next   = b_reg[0] ? acc_reg : base_reg;
                    my_next   = base_reg;
                    macc_next = '0;
                    mcnt_next = MUL_TOP;
                    ret_next  = b_reg[0] ? ST_POW_ACC : ST_POW_SQ;
                end
            end
            ST_POW_ACC:
            begin
                acc_next  = macc_reg;
                mx_next   = base_reg;
                my_next   = base_reg;
                macc_next = '0;
                mcnt_next = MUL_TOP;
                ret_next  = ST_POW_SQ;
            end
            ST_POW_SQ:
            begin
                base_next = macc_reg;
                b_next    = b_reg >> 1;
            end
            ST_MUL_DBL:
            begin
                ctl.x     = macc_reg;
                ctl.y     = macc_reg;
                macc_next = alu_res;
            end
            ST_MUL_ADD:
            begin
                if (my_reg[RES_W-1])
                begin
                    ctl.x     = macc_reg;
                    ctl.y     = mx_reg;
                    macc_next = alu_res;
                end
                my_next   = my_reg << 1;
                mcnt_next = mcnt_reg - MCW'(1);
            end
            ST_MUL_RES:
            begin
                res_next = macc_reg;
            end
            ST_FINISH:
            begin
                res_next = res_reg;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        ar_reg   <= ar_next;
        br_reg   <= br_next;
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        s0_reg   <= s0_next;
        s1_reg   <= s1_next;
        q_reg    <= q_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        macc_reg <= macc_next;
        mcnt_reg <= mcnt_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        res_reg  <= res_next;
    end
endmodule

@@ hw/rtl/modular_arithmetic_unit.sv @@
// Steps: both operands are reduced bit by bit, then add/sub is done directly, multiply runs a
// double-and-add loop, inverse runs Euclid steps (divide adds a multiply at the end), power
// squares per exponent bit and multiplies into the accumulator when the bit is set; then finish.
// One item at a time through the single shared add/compare unit; the next is taken once
// the sequencer is back in idle, while the previous result may still wait at the output.
// Reset: modulus returns to 1000000007, sequencer idle, output register empty.
`timescale 1ns / 1ps
`include "modular_arithmetic_unit_macros.svh"
module modular_arithmetic_unit #(
    parameter int OPERAND_BITS = mau_pkg::OPERAND_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mau_pkg::RES_W-1:0]   cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  action,
    input  logic [OPERAND_BITS-1:0]     operand_a,
    input  logic [OPERAND_BITS-1:0]     operand_b,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mau_pkg::RES_W-1:0]   result
);
    import mau_pkg::*;

    logic [RES_W-1:0] modulus_reg;
    logic             out_valid_reg;
    logic [RES_W-1:0] result_reg;
    logic             busy;
    logic             push;
    logic             out_free;
    logic [RES_W-1:0] seq_res;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = busy;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    mau_seq #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && !busy),
        .action    (action),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .modulus   (modulus_reg),
        .out_free  (out_free),
        .busy      (busy),
        .push      (push),
        .res       (seq_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= MODULUS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                modulus_reg <= cfg_wdata;
            if (push)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            result_reg <= seq_res;
    end

    `MAU_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
    `MAU_ASSERT_NOW(a_result_in_range, out_valid && modulus_reg >= RES_W'(2), result < modulus_reg)
    `MAU_ASSERT_NEXT(a_push_fills, push, out_valid)
endmodule

@@ sim/modular_arithmetic_unit_test.sv @@
// Self-checking testbench for the modular arithmetic unit: directed and random operations
`timescale 1ns / 1ps
module modular_arithmetic_unit_test;
    import mau_pkg::*;

    localparam int OPW = 63;
    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;
    localparam logic [OPW-1:0] OP_MAX = {OPW{1'b1}};
    localparam longint unsigned CYCLE_LIMIT = 40000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [RES_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] action = ACT_ADD;
    logic [OPW-1:0] operand_a = '0;
    logic [OPW-1:0] operand_b = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [RES_W-1:0] result;

    logic [RES_W-1:0] residues_due[$];
    longint unsigned cur_modulus;
    longint unsigned cycles = 0;
    int mismatches = 0;
    int burst_left = 0;

    modular_arithmetic_unit #(.OPERAND_BITS(OPW)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(out_valid), .out_stall(out_stall), .result(result)
    );

    always #5 clk = ~clk;

    // Extended Euclid; non-coprime operands give the reduced Bezout coefficient
    function automatic longint unsigned mod_inverse(longint unsigned x, longint unsigned m);
        longint r0, r1, s0, s1, q, nr, ns;
        r0 = longint'(x % m);
        r1 = longint'(m);
        s0 = 1;
        s1 = 0;
        while (r1 != 0)
        begin
            q = r0 / r1;
            nr = r0 - q * r1;
            ns = s0 - q * s1;
            r0 = r1;
            r1 = nr;
            s0 = s1;
            s1 = ns;
        end
        s0 = s0 % longint'(m);
        if (s0 < 0)
            s0 = s0 + longint'(m);
        return longint'(s0);
    endfunction

    function automatic longint unsigned mod_power(longint unsigned base, longint unsigned e,
                                                  longint unsigned m);
        longint unsigned acc;
        acc = 1 % m;
        base = base % m;
        while (e != 0)
        begin
            if (e[0])
                acc = acc * base % m;
            base = base * base % m;
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic [RES_W-1:0] residue_of(logic [2:0] act, logic [OPW-1:0] a,
                                                    logic [OPW-1:0] b);
        longint unsigned m, ar, br, r;
        m = cur_modulus;
        r = 0;
        if (m >= 2)
        begin
            ar = a % m;
            br = b % m;
            case (act)
                ACT_ADD: r = (ar + br) % m;
                ACT_SUB: r = (ar + m - br) % m;
                ACT_MUL: r = ar * br % m;
                ACT_DIV: r = ar * mod_inverse(b, m) % m;
                ACT_INV: r = mod_inverse(a, m);
                ACT_POW: r = mod_power(a, b, m);
                default: r = 0;
            endcase
        end
        return r[RES_W-1:0];
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result checker and receiver stall pattern
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (residues_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d", result);
            end
            else
            begin
                if (result !== residues_due[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %0d, got %0d",
                                 residues_due[0], result);
                end
                void'(residues_due.pop_front());
            end
        end
        case (cycles[11:10])
            2'd0: out_stall <= 1'b0;
            2'd1: out_stall <= $urandom_range(0, 1);
            2'd2: out_stall <= (cycles[4:0] < 5'd23);
            default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_item(logic [2:0] act, logic [OPW-1:0] a, logic [OPW-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_valid <= 1'b1;
        action <= act;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        residues_due.push_back(residue_of(act, a, b));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (residues_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_modulus(logic [RES_W-1:0] m);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cur_modulus = m;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [OPW-1:0] rand_operand();
        logic [OPW-1:0] v;
        v = OPW'({$urandom, $urandom});
        case ($urandom_range(0, 5))
            0: v = OPW'($urandom_range(0, 20));
            1: v = OPW'(cur_modulus * $urandom_range(0, 3) + $urandom_range(0, 2));
            2: v = OP_MAX - OPW'($urandom_range(0, 3));
            3: v = v >> $urandom_range(0, 62);
            default: ;
        endcase
        return v;
    endfunction

    // Exponents are mostly short: each exponent bit costs a long multiply loop
    function automatic logic [OPW-1:0] rand_exponent();
        if ($urandom_range(0, 39) == 0)
            return OPW'({$urandom, $urandom});
        return OPW'($urandom_range(0, 4095));
    endfunction

    task automatic test_directed;
        send_item(ACT_ADD, OP_MAX, OP_MAX);
        send_item(ACT_ADD, 0, 0);
        send_item(ACT_SUB, 0, OP_MAX);
        send_item(ACT_SUB, 12345, 12345);
        send_item(ACT_MUL, OP_MAX, OP_MAX);
        send_item(ACT_MUL, OPW'(cur_modulus - 1), OPW'(cur_modulus - 1));
        send_item(ACT_DIV, 7, 0);
        send_item(ACT_DIV, OP_MAX, 1);
        send_item(ACT_DIV, 5, OPW'(cur_modulus));
        send_item(ACT_INV, 0, OP_MAX);
        send_item(ACT_INV, 1, 0);
        send_item(ACT_INV, OPW'(cur_modulus - 1), 0);
        send_item(ACT_INV, OPW'(cur_modulus * 3), 0);
        send_item(ACT_INV, OP_MAX, 0);
        send_item(ACT_POW, 0, 0);
        send_item(ACT_POW, OP_MAX, 0);
        send_item(ACT_POW, OPW'(cur_modulus - 1), OP_MAX);
        send_item(ACT_POW, 2, 62);
        send_item(ACT_POW, OPW'(cur_modulus), 3);
        send_item(ACT_RSVD6, OP_MAX, OP_MAX);
        send_item(ACT_RSVD7, 99, 3);
    endtask

    task automatic test_random(int count);
        logic [2:0] act;
        repeat (count)
        begin
            act = ($urandom_range(0, 24) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
            send_item(act, rand_operand(), act == ACT_POW ? rand_exponent() : rand_operand());
        end
    endtask

    // Modulus below two forces zero for every action
    task automatic test_degenerate_modulus;
        set_modulus(0);
        test_random(20);
        set_modulus(1);
        test_random(20);
    endtask

    initial
    begin
        cur_modulus = MODULUS_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(300);
        set_modulus(2);
        test_directed();
        test_random(100);
        set_modulus(31'h7FFF_FFFF);
        test_directed();
        test_random(150);
        set_modulus(1000000000);
        test_random(120);
        set_modulus(12);
        test_random(100);
        test_degenerate_modulus();
        set_modulus(MODULUS_RESET);
        test_random(300);
        drain();
        repeat (300) @(posedge clk);
        if (mismatches == 0 && residues_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
